### design/fcrm_pkg.sv
// shared types, constants and the level-to-color ramp for the false color range mapper
// no dependencies; every other design file refers to this package by scoped names
package fcrm_pkg;

   localparam int SAMPLE_WIDTH = 32;
   localparam int IN_WIDTH     = 32;
   localparam int LEVEL_BITS   = 10;
   localparam int COLOR_BITS   = 8;
   localparam int STEP_BITS    = $clog2(LEVEL_BITS);
   localparam int DIV_WIDTH    = SAMPLE_WIDTH + LEVEL_BITS;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {LEVEL_BITS{1'b1}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAXV = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MINV = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_ACCUM = 2'd1;
   localparam logic [1:0] OP_MAP   = 2'd2;

   typedef struct packed {
      logic [1:0]                 opcode;
      logic signed [IN_WIDTH-1:0] sample;
   } req_word_type;

   typedef struct packed {
      logic [COLOR_BITS-1:0] red;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] blue;
      logic [LEVEL_BITS-1:0] level;
   } rsp_word_type;

   // forced jobs carry their final level, the rest carry offset and span for the divider
   typedef struct packed {
      logic                    forced;
      logic [LEVEL_BITS-1:0]   level;
      logic [SAMPLE_WIDTH-1:0] offset;
      logic [SAMPLE_WIDTH-1:0] span;
   } map_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_LOAD,
      BACK_DIVIDE,
      BACK_DONE
   } back_state_type;

   // blue -> cyan -> green -> yellow -> red, one 256-step ramp per quarter
   function automatic rsp_word_type level_to_color(input logic [LEVEL_BITS-1:0] level);
      rsp_word_type          c;
      logic [COLOR_BITS-1:0] low;
      low     = level[COLOR_BITS-1:0];
      c.level = level;
      case (level[LEVEL_BITS-1:COLOR_BITS])
         2'd0: begin
            c.red   = '0;
            c.green = low;
            c.blue  = '1;
         end
         2'd1: begin
            c.red   = '0;
            c.green = '1;
            c.blue  = ~low;
         end
         2'd2: begin
            c.red   = low;
            c.green = '1;
            c.blue  = '0;
         end
         default: begin
            c.red   = '1;
            c.green = ~low;
            c.blue  = '0;
         end
      endcase
      return c;
   endfunction

endpackage

### design/false_color_range_mapper.sv
// top level of the false color range mapper: front end, job queue and divider back end
// depends on fcrm_pkg, fcrm_front, fcrm_queue and fcrm_back
//
// Usage:
//   req_valid/req_ready/req_data carry one word each: an opcode and a signed sample.
//   clear resets the running range, accumulate widens it with the sample, map turns
//   the sample into a 10-bit level and a blue-to-red color; unused opcodes are dropped.
//   Only map words produce a rsp word, on rsp_valid/rsp_ready/rsp_data.
//   Clear and accumulate words pass the front end back to back.
//   A map word whose level needs the divider goes through the back end as a queue
//   pop, a setup step, ten restoring divide steps and a result write; a forced
//   level (empty or single-value range, sample at or beyond an end) goes from the
//   queue pop straight to the result write.
//   The bit-serial divider finishes one map word before it pops the next job.
//   A two-entry job queue lets the front end keep taking words while the divider
//   works; when rsp_ready is low the result register holds, the back end waits, and
//   once the queue fills a held map word drops req_ready until a slot frees.
//   Reset empties the pipeline and sets the range to empty (low at the most positive,
//   high at the most negative value).
module false_color_range_mapper (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  fcrm_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output fcrm_pkg::rsp_word_type rsp_data
);

   fcrm_pkg::queue_status_type queue_status;
   fcrm_pkg::map_job_type      push_job;
   fcrm_pkg::map_job_type      head_job;
   logic                       queue_push;
   logic                       queue_pop;

   fcrm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .queue_status (queue_status),
      .push         (queue_push),
      .job          (push_job)
   );

   fcrm_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (queue_push),
      .push_job     (push_job),
      .pop          (queue_pop),
      .head_job     (head_job),
      .queue_status (queue_status)
   );

   fcrm_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .head_job     (head_job),
      .pop          (queue_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

   // front end never pushes into a full queue, back end never pops an empty one
   assert property (@(posedge clock) disable iff (reset)
      queue_push |-> !queue_status.full)
      else $error("push into full job queue");

   assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> !queue_status.empty)
      else $error("pop from empty job queue");

   // color must match the reported level
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data == fcrm_pkg::level_to_color(rsp_data.level)))
      else $error("color does not match level");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

### design/fcrm_front.sv
// front end: holds one request word, keeps the running range and classifies map words
// depends on fcrm_pkg
module fcrm_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  fcrm_pkg::req_word_type     req_data,
   input  fcrm_pkg::queue_status_type queue_status,
   output logic                       push,
   output fcrm_pkg::map_job_type      job
);

   logic                                    held_valid_ff, held_valid_in;
   fcrm_pkg::req_word_type                  held_ff, held_in;
   logic signed [fcrm_pkg::SAMPLE_WIDTH-1:0] range_low_ff, range_low_in;
   logic signed [fcrm_pkg::SAMPLE_WIDTH-1:0] range_high_ff, range_high_in;
   logic signed [fcrm_pkg::SAMPLE_WIDTH-1:0] value;
   logic                                    map_word;
   logic                                    go;
   logic                                    take;

   always_comb begin
      value    = fcrm_pkg::SAMPLE_WIDTH'(held_ff.sample);
      map_word = (held_ff.opcode == fcrm_pkg::OP_MAP);
      go       = held_valid_ff && (!map_word || !queue_status.full);
      push     = held_valid_ff && map_word && !queue_status.full;
      req_ready = !held_valid_ff || go;
      take     = req_valid && req_ready;

      held_in       = take ? req_data : held_ff;
      held_valid_in = take || (held_valid_ff && !go);

      // snapshot of the range as it stands for this word
      job.span   = range_high_ff - range_low_ff;
      job.offset = value - range_low_ff;
      if (range_high_ff <= range_low_ff || value <= range_low_ff) begin
         job.forced = 1'b1;
         job.level  = '0;
      end else if (value >= range_high_ff) begin
         job.forced = 1'b1;
         job.level  = fcrm_pkg::LEVEL_MAX;
      end else begin
         job.forced = 1'b0;
         job.level  = '0;
      end

      range_low_in  = range_low_ff;
      range_high_in = range_high_ff;
      if (go) begin
         case (held_ff.opcode)
            fcrm_pkg::OP_CLEAR: begin
               range_low_in  = fcrm_pkg::SAMPLE_MAXV;
               range_high_in = fcrm_pkg::SAMPLE_MINV;
            end
            fcrm_pkg::OP_ACCUM: begin
               if (value < range_low_ff) range_low_in = value;
               if (value > range_high_ff) range_high_in = value;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         range_low_ff  <= fcrm_pkg::SAMPLE_MAXV;
         range_high_ff <= fcrm_pkg::SAMPLE_MINV;
      end else begin
         held_valid_ff <= held_valid_in;
         range_low_ff  <= range_low_in;
         range_high_ff <= range_high_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

### design/fcrm_queue.sv
// short job queue between the front end and the divider back end
// depends on fcrm_pkg
module fcrm_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  fcrm_pkg::map_job_type      push_job,
   input  logic                       pop,
   output fcrm_pkg::map_job_type      head_job,
   output fcrm_pkg::queue_status_type queue_status
);

   fcrm_pkg::map_job_type              entries_ff [fcrm_pkg::QUEUE_DEPTH];
   logic [fcrm_pkg::QUEUE_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [fcrm_pkg::QUEUE_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [fcrm_pkg::QUEUE_AW:0]        count_ff, count_in;
   logic                               do_push;
   logic                               do_pop;

   always_comb begin
      queue_status.full  = (count_ff == (fcrm_pkg::QUEUE_AW + 1)'(fcrm_pkg::QUEUE_DEPTH));
      queue_status.empty = (count_ff == '0);
      do_push  = push && !queue_status.full;
      do_pop   = pop && !queue_status.empty;
      head_job = entries_ff[rd_ptr_ff];

      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### design/fcrm_back.sv
// back end: restoring divider for the level, color ramp lookup and the result register
// depends on fcrm_pkg
module fcrm_back (
   input  logic                       clock,
   input  logic                       reset,
   input  fcrm_pkg::queue_status_type queue_status,
   input  fcrm_pkg::map_job_type      head_job,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output fcrm_pkg::rsp_word_type     rsp_data
);

   fcrm_pkg::back_state_type            state_ff, state_in;
   logic [fcrm_pkg::SAMPLE_WIDTH-1:0]   offset_ff, offset_in;
   logic [fcrm_pkg::SAMPLE_WIDTH-1:0]   span_ff, span_in;
   logic [fcrm_pkg::SAMPLE_WIDTH-1:0]   rem_ff, rem_in;
   logic [fcrm_pkg::LEVEL_BITS-1:0]     shift_ff, shift_in;
   logic [fcrm_pkg::STEP_BITS-1:0]      step_ff, step_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   fcrm_pkg::rsp_word_type              rsp_data_ff, rsp_data_in;
   logic [fcrm_pkg::DIV_WIDTH-1:0]      dividend;
   logic [fcrm_pkg::SAMPLE_WIDTH:0]     trial;
   logic                                fits;

   always_comb begin
      state_in     = state_ff;
      offset_in    = offset_ff;
      span_in      = span_ff;
      rem_in       = rem_ff;
      shift_in     = shift_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;

      // offset * 1023 as offset * 1024 - offset
      dividend = {offset_ff, {fcrm_pkg::LEVEL_BITS{1'b0}}}
                 - fcrm_pkg::DIV_WIDTH'(offset_ff);
      trial    = {rem_ff, shift_ff[fcrm_pkg::LEVEL_BITS-1]};
      fits     = (trial >= {1'b0, span_ff});

      case (state_ff)
         fcrm_pkg::BACK_IDLE: begin
            if (!queue_status.empty) begin
               pop       = 1'b1;
               offset_in = head_job.offset;
               span_in   = head_job.span;
               shift_in  = head_job.level;
               state_in  = head_job.forced ? fcrm_pkg::BACK_DONE : fcrm_pkg::BACK_LOAD;
            end
         end
         fcrm_pkg::BACK_LOAD: begin
            // upper part is below span because the quotient stays under 1024
            rem_in   = dividend[fcrm_pkg::DIV_WIDTH-1:fcrm_pkg::LEVEL_BITS];
            shift_in = dividend[fcrm_pkg::LEVEL_BITS-1:0];
            step_in  = fcrm_pkg::STEP_BITS'(fcrm_pkg::LEVEL_BITS - 1);
            state_in = fcrm_pkg::BACK_DIVIDE;
         end
         fcrm_pkg::BACK_DIVIDE: begin
            // dividend bits shift out the top while quotient bits shift in below
            rem_in   = fits ? fcrm_pkg::SAMPLE_WIDTH'(trial - {1'b0, span_ff})
                            : trial[fcrm_pkg::SAMPLE_WIDTH-1:0];
            shift_in = {shift_ff[fcrm_pkg::LEVEL_BITS-2:0], fits};
            step_in  = step_ff - 1'b1;
            if (step_ff == '0) state_in = fcrm_pkg::BACK_DONE;
         end
         fcrm_pkg::BACK_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = fcrm_pkg::level_to_color(shift_ff);
               state_in     = fcrm_pkg::BACK_IDLE;
            end
         end
         default: begin
            state_in = fcrm_pkg::BACK_IDLE;
         end
      endcase

      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fcrm_pkg::BACK_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff   <= offset_in;
      span_ff     <= span_in;
      rem_ff      <= rem_in;
      shift_ff    <= shift_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
